// File: rtl/gmac_pkg.sv
// ----------------------------------------------------------------------------
// gmac_pkg: shared types and constants for the GF(2^128) batched MAC check
// Field width, reduction constant, register indices, multiplier request/response and sequencer states.
// ----------------------------------------------------------------------------
package gmac_pkg;

  localparam int unsigned FieldWidth = 128;
  localparam int unsigned HalfWidth  = 64;
  localparam int unsigned RegIdxWidth = 1;

  localparam logic [RegIdxWidth-1:0] RegKeyLow  = 1'b0;
  localparam logic [RegIdxWidth-1:0] RegKeyHigh = 1'b1;

  // x^128 = x^7 + x^2 + x + 1
  localparam logic [FieldWidth-1:0] ReducePoly = 128'h87;

  typedef logic [FieldWidth-1:0] gf_elem_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_TAG,
    ST_KEY
  } seq_state_t;

  typedef struct packed {
    logic     start;
    gf_elem_t mult_a;
    gf_elem_t mult_b;
  } mul_req_t;

  typedef struct packed {
    logic     done;
    gf_elem_t product;
  } mul_rsp_t;

endpackage

// File: rtl/gmac_cell.sv
// ----------------------------------------------------------------------------
// gmac_cell: one Horner step of the GF(2^128) multiplier
// Shift the partial product one place, reduce, and add a when the b bit is set.
// ----------------------------------------------------------------------------
module gmac_cell (
  input  gmac_pkg::gf_elem_t acc_in,
  input  gmac_pkg::gf_elem_t mult_a,
  input  logic               b_bit,
  output gmac_pkg::gf_elem_t acc_out
);
  import gmac_pkg::*;

  gf_elem_t shifted;

  always_comb begin
    shifted = {acc_in[FieldWidth-2:0], 1'b0};
    if (acc_in[FieldWidth-1]) begin
      shifted = shifted ^ ReducePoly;
    end
    acc_out = b_bit ? (shifted ^ mult_a) : shifted;
  end

endmodule

// File: rtl/gmac_mul.sv
// ----------------------------------------------------------------------------
// gmac_mul: GF(2^128) multiplier built as a chain of Horner cells
// CellsPerCycle cells in a row consume that many b bits per clock while a pass is busy.
// ----------------------------------------------------------------------------
module gmac_mul #(
  parameter int unsigned CellsPerCycle = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  gmac_pkg::mul_req_t req,
  output gmac_pkg::mul_rsp_t rsp
);
  import gmac_pkg::*;

  localparam int unsigned Steps    = FieldWidth / CellsPerCycle;
  localparam int unsigned CntWidth = $clog2(Steps + 1);

  gf_elem_t             acc;
  gf_elem_t             a_hold;
  gf_elem_t             b_hold;
  logic [CntWidth-1:0]  count;
  logic                 busy;
  logic                 done;
  gf_elem_t             chain [CellsPerCycle+1];

  assign chain[0] = acc;

  for (genvar g = 0; g < CellsPerCycle; g++) begin : g_cell
    gmac_cell u_cell (
      .acc_in (chain[g]),
      .mult_a (a_hold),
      .b_bit  (b_hold[FieldWidth-1-g]),
      .acc_out(chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CntWidth'(Steps);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc    <= '0;
      a_hold <= req.mult_a;
      b_hold <= req.mult_b;
    end else if (busy) begin
      acc    <= chain[CellsPerCycle];
      b_hold <= b_hold << CellsPerCycle;
    end
  end

  assign rsp = '{done: done, product: acc};

endmodule

// File: rtl/gf128_batched_mac_check_unit.sv
// ----------------------------------------------------------------------------
// gf128_batched_mac_check_unit: batched MAC check of two-party shares over GF(2^128)
// Joins shares, multiplies by the challenge, accumulates, and checks the key
// product against the accumulated tag on the last pair of a batch.
// ----------------------------------------------------------------------------
// Channel   Signals                                        Direction
// in        in_valid, in_stall, data/tag/challenge, last   consumer
// out       out_valid, out_stall, check_passed             producer
// cfg       cfg_we, cfg_index, cfg_data                    consumer
//
// One transaction takes 2 multiplier passes, plus a third on the last pair;
// each pass is started by the registered pending flag or by a done pulse, and
// the sequencer returns to idle once the final multiplier pass has completed.
// Reset clears the accumulators, key and control. in_stall is high while a
// transaction is in flight, or while a result waits and a last pair is offered;
// a held result does not block accumulation of the next non-last transaction.
// ----------------------------------------------------------------------------
module gf128_batched_mac_check_unit #(
  parameter int unsigned CellsPerCycle = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [gmac_pkg::RegIdxWidth-1:0]     cfg_index,
  input  logic [gmac_pkg::HalfWidth-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [gmac_pkg::HalfWidth-1:0]       data_a_low,
  input  logic [gmac_pkg::HalfWidth-1:0]       data_a_high,
  input  logic [gmac_pkg::HalfWidth-1:0]       tag_a_low,
  input  logic [gmac_pkg::HalfWidth-1:0]       tag_a_high,
  input  logic [gmac_pkg::HalfWidth-1:0]       data_b_low,
  input  logic [gmac_pkg::HalfWidth-1:0]       data_b_high,
  input  logic [gmac_pkg::HalfWidth-1:0]       tag_b_low,
  input  logic [gmac_pkg::HalfWidth-1:0]       tag_b_high,
  input  logic [gmac_pkg::HalfWidth-1:0]       challenge_low,
  input  logic [gmac_pkg::HalfWidth-1:0]       challenge_high,
  input  logic                                 last_pair,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 check_passed
);
  import gmac_pkg::*;

  seq_state_t state, state_next;
  gf_elem_t   mac_key;
  gf_elem_t   data_acc;
  gf_elem_t   tag_acc;
  gf_elem_t   data_join;
  gf_elem_t   tag_join;
  gf_elem_t   challenge;
  logic       last_hold;
  logic       pending;
  mul_req_t   req;
  mul_rsp_t   rsp;
  logic       in_fire;

  assign in_fire  = in_valid && !in_stall;
  // a last transaction needs the output register free
  assign in_stall = (state != ST_IDLE) || req.start || (out_valid && last_pair);

  gmac_mul #(.CellsPerCycle(CellsPerCycle)) u_mul (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_DATA;
      ST_DATA: if (rsp.done) state_next = ST_TAG;
      ST_TAG:  if (rsp.done) state_next = last_hold ? ST_KEY : ST_IDLE;
      ST_KEY:  if (rsp.done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.start  = pending;
    req.mult_a = challenge;
    req.mult_b = data_join;
    case (state)
      ST_DATA: begin
        req.start = pending || rsp.done;
        if (!pending) begin
          req.mult_b = tag_join;
        end
      end
      ST_TAG: begin
        req.start  = rsp.done && last_hold;
        req.mult_a = mac_key;
        req.mult_b = data_acc;
      end
      default: begin
        req.start = pending;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= 1'b0;
      mac_key   <= '0;
      data_acc  <= '0;
      tag_acc   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          RegKeyLow:  mac_key[HalfWidth-1:0]          <= cfg_data;
          RegKeyHigh: mac_key[FieldWidth-1:HalfWidth] <= cfg_data;
          default:    mac_key <= mac_key;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        pending <= 1'b1;
      end
      if (rsp.done) begin
        case (state)
          ST_DATA: data_acc <= data_acc ^ rsp.product;
          ST_TAG:  tag_acc  <= tag_acc ^ rsp.product;
          ST_KEY: begin
            out_valid    <= 1'b1;
            check_passed <= (rsp.product == tag_acc);
            data_acc     <= '0;
            tag_acc      <= '0;
          end
          default: data_acc <= data_acc;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      data_join <= {data_a_high ^ data_b_high, data_a_low ^ data_b_low};
      tag_join  <= {tag_a_high ^ tag_b_high, tag_a_low ^ tag_b_low};
      challenge <= {challenge_high, challenge_low};
      last_hold <= last_pair;
    end
  end

endmodule

// File: rtl/gmac_checker.sv
// ----------------------------------------------------------------------------
// gmac_checker: port-level assertions for the batched MAC check unit
// Watches handshakes and result timing from the top-level ports.
// ----------------------------------------------------------------------------
module gmac_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic last_pair,
  input logic out_valid,
  input logic out_stall,
  input logic check_passed
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(check_passed))
    else $error("result dropped or changed under stall");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_no_result_soon: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_valid && last_pair |-> in_stall)
    else $error("last transaction taken while result pending");

endmodule

bind gf128_batched_mac_check_unit gmac_checker u_gmac_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .last_pair(last_pair), .out_valid(out_valid), .out_stall(out_stall),
  .check_passed(check_passed)
);
